### hw/rtl/assert_macros.svh
// Assertion helpers: clocked, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TST_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define TST_ASSERT_MSG(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`endif

### hw/rtl/tst_pkg.sv
package tst_pkg;

  localparam int SEG_VERTS = 6*3;
  localparam int DOT_VERTS = 2*3;
  localparam logic signed [17:0] TEX_ONE = 18'sd16384;

  localparam logic [1:0] CT_NEG  = 2'd0;
  localparam logic [1:0] CT_ZERO = 2'd1;
  localparam logic [1:0] CT_POS  = 2'd2;

  typedef struct packed {
    logic              mode;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]       r;
    logic [31:0]       rgba;
  } side_t;

  typedef struct packed {
    side_t              sd;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [33:0] nwx;
    logic signed [33:0] nwy;
    logic signed [33:0] twx;
  } geo_t;

  function automatic logic [2:0] seg_corner(input logic [4:0] k);
    logic [2:0] c;
    c = 3'd0;
    unique case (k)
      5'd0:  c = 3'd0;
      5'd1:  c = 3'd1;
      5'd2:  c = 3'd2;
      5'd3:  c = 3'd3;
      5'd4:  c = 3'd1;
      5'd5:  c = 3'd2;
      5'd6:  c = 3'd3;
      5'd7:  c = 3'd4;
      5'd8:  c = 3'd2;
      5'd9:  c = 3'd3;
      5'd10: c = 3'd4;
      5'd11: c = 3'd5;
      5'd12: c = 3'd6;
      5'd13: c = 3'd4;
      5'd14: c = 3'd5;
      5'd15: c = 3'd6;
      5'd16: c = 3'd7;
      5'd17: c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] seg_ct(input logic [2:0] c);
    logic [1:0] t;
    t = CT_ZERO;
    unique case (c)
      3'd0, 3'd1: t = CT_NEG;
      3'd6, 3'd7: t = CT_POS;
      default:    t = CT_ZERO;
    endcase
    return t;
  endfunction

  function automatic logic [1:0] dot_corner(input logic [4:0] k);
    logic [1:0] c;
    c = 2'd0;
    unique case (k)
      5'd0:    c = 2'd0;
      5'd1:    c = 2'd1;
      5'd2:    c = 2'd2;
      5'd3:    c = 2'd0;
      5'd4:    c = 2'd2;
      5'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] s;
    if (v > 36'sd2147483647) s = 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) s = 32'sh80000000;
    else s = v[31:0];
    return s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] s;
    if (v > 18'sd32767) s = 16'sh7FFF;
    else if (v < -18'sd32768) s = 16'sh8000;
    else s = v[15:0];
    return s;
  endfunction

endpackage

### hw/rtl/tst_geom.sv
module tst_geom import tst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  side_t              in_side,
  output logic               geo_valid,
  input  logic               geo_take,
  output geo_t               geo
);

  localparam int NST = 57;
  localparam int SGN = 54;
  localparam int MUL = 55;

  logic  en;
  logic  vld [0:NST-1];
  side_t sd  [0:NST-1];

  logic [31:0] mx1, my1, mx2, my2;
  logic        big2;
  logic [4:0]  lsh2;
  logic [30:0] smx3, smy3, smx4, smy4;
  logic [61:0] sqx4, sqy4;

  logic [63:0] rt_rem  [0:32];
  logic [31:0] rt_root [0:32];
  logic [30:0] rt_mx   [0:32];
  logic [30:0] rt_my   [0:32];

  logic [46:0] dv_remx [0:15];
  logic [46:0] dv_remy [0:15];
  logic [14:0] dv_qx   [0:15];
  logic [14:0] dv_qy   [0:15];
  logic [31:0] dv_len  [0:15];

  logic signed [15:0] nx, ny;
  logic signed [15:0] pnx_hold_nx, pnx_hold_ny;
  logic signed [47:0] pnx, pny;
  geo_t               tail;

  logic signed [32:0] dx0, dy0;
  logic [31:0]        m1;
  logic [4:0]         lsh_c;
  logic               dxneg, dypos, zlen;

  assign en        = !vld[NST-1] || geo_take;
  assign in_stall  = !en;
  assign geo_valid = vld[NST-1];
  assign geo       = tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= in_side;
      for (int i = 1; i < NST; i++) sd[i] <= sd[i-1];
    end
  end

  always_comb begin
    dx0 = {sd[0].bx[31], sd[0].bx} - {sd[0].ax[31], sd[0].ax};
    dy0 = {sd[0].by[31], sd[0].by} - {sd[0].ay[31], sd[0].ay};
    m1  = (mx1 > my1) ? mx1 : my1;
    lsh_c = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (m1[i]) lsh_c = 5'(30 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx1  <= dx0[32] ? 32'(-dx0) : dx0[31:0];
      my1  <= dy0[32] ? 32'(-dy0) : dy0[31:0];
      mx2  <= mx1;
      my2  <= my1;
      big2 <= m1[31];
      lsh2 <= lsh_c;
      smx3 <= big2 ? mx2[31:1] : 31'(mx2 << lsh2);
      smy3 <= big2 ? my2[31:1] : 31'(my2 << lsh2);
      smx4 <= smx3;
      smy4 <= smy3;
      sqx4 <= 62'(smx3) * 62'(smx3);
      sqy4 <= 62'(smy3) * 62'(smy3);
      rt_rem[0]  <= 64'(sqx4) + 64'(sqy4);
      rt_root[0] <= 32'd0;
      rt_mx[0]   <= smx4;
      rt_my[0]   <= smy4;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    localparam int B = 31 - j;
    logic [63:0] trial;
    assign trial = (64'(rt_root[j]) << (B + 1)) | (64'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rt_rem[j] >= trial) begin
          rt_rem[j+1]  <= rt_rem[j] - trial;
          rt_root[j+1] <= rt_root[j] | (32'd1 << B);
        end else begin
          rt_rem[j+1]  <= rt_rem[j];
          rt_root[j+1] <= rt_root[j];
        end
        rt_mx[j+1] <= rt_mx[j];
        rt_my[j+1] <= rt_my[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_remx[0] <= {2'b0, rt_my[32], 14'b0} + 47'(rt_root[32] >> 1);
      dv_remy[0] <= {2'b0, rt_mx[32], 14'b0} + 47'(rt_root[32] >> 1);
      dv_qx[0]   <= 15'd0;
      dv_qy[0]   <= 15'd0;
      dv_len[0]  <= rt_root[32];
    end
  end

  for (genvar j = 0; j < 15; j++) begin : g_div
    localparam int B = 14 - j;
    logic [46:0] dsh;
    assign dsh = 47'(dv_len[j]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (dv_remx[j] >= dsh) begin
          dv_remx[j+1] <= dv_remx[j] - dsh;
          dv_qx[j+1]   <= dv_qx[j] | (15'd1 << B);
        end else begin
          dv_remx[j+1] <= dv_remx[j];
          dv_qx[j+1]   <= dv_qx[j];
        end
        if (dv_remy[j] >= dsh) begin
          dv_remy[j+1] <= dv_remy[j] - dsh;
          dv_qy[j+1]   <= dv_qy[j] | (15'd1 << B);
        end else begin
          dv_remy[j+1] <= dv_remy[j];
          dv_qy[j+1]   <= dv_qy[j];
        end
        dv_len[j+1] <= dv_len[j];
      end
    end
  end

  always_comb begin
    dxneg = sd[SGN-1].bx < sd[SGN-1].ax;
    dypos = sd[SGN-1].by > sd[SGN-1].ay;
    zlen  = (sd[SGN-1].bx == sd[SGN-1].ax) && (sd[SGN-1].by == sd[SGN-1].ay);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zlen) begin
        nx <= 16'sd0;
        ny <= 16'sd0;
      end else begin
        nx <= dypos ? -$signed({1'b0, dv_qx[15]}) : $signed({1'b0, dv_qx[15]});
        ny <= dxneg ? -$signed({1'b0, dv_qy[15]}) : $signed({1'b0, dv_qy[15]});
      end
      pnx <= 48'(nx) * $signed({17'b0, sd[SGN].r});
      pny <= 48'(ny) * $signed({17'b0, sd[SGN].r});
      tail.sd  <= sd[MUL];
      tail.nx  <= 16'(pnx_hold_nx);
      tail.ny  <= 16'(pnx_hold_ny);
      tail.nwx <= 34'((pnx + 48'sd8192) >>> 14);
      tail.nwy <= 34'((pny + 48'sd8192) >>> 14);
      tail.twx <= 34'((-pny + 48'sd8192) >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pnx_hold_nx <= nx;
      pnx_hold_ny <= ny;
    end
  end

endmodule

### hw/rtl/tst_emit.sv
module tst_emit import tst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               geo_valid,
  output logic               geo_take,
  input  geo_t               geo,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] vert_x,
  output logic signed [31:0] vert_y,
  output logic [31:0]        vert_rgba,
  output logic signed [15:0] tex_u,
  output logic signed [15:0] tex_v,
  output logic [4:0]         vert_index,
  output logic               last_vertex
);

  geo_t       cur;
  logic       cur_valid;
  logic [4:0] k;
  logic [4:0] last_k;
  logic       out_adv, at_last, free;

  logic [2:0]         c;
  logic [1:0]         ct, dc;
  logic signed [35:0] bpx, bpy, npx, npy, tpx, tpy, rr;
  logic signed [17:0] nxe, nye, un, vn, ut, vt;
  logic signed [31:0] px, py;
  logic signed [15:0] pu, pv;

  assign out_adv  = !out_valid || !out_stall;
  assign last_k   = cur.sd.mode ? 5'(SEG_VERTS - 1) : 5'(DOT_VERTS - 1);
  assign at_last  = (k == last_k);
  assign free     = !cur_valid || (out_adv && at_last);
  assign geo_take = geo_valid && free;

  always_comb begin
    c   = seg_corner(k);
    ct  = seg_ct(c);
    dc  = dot_corner(k);
    nxe = {{2{cur.nx[15]}}, cur.nx};
    nye = {{2{cur.ny[15]}}, cur.ny};
    rr  = 36'(cur.sd.r);
    if (cur.sd.mode) begin
      bpx = c[2] ? 36'(cur.sd.ax) : 36'(cur.sd.bx);
      bpy = c[2] ? 36'(cur.sd.ay) : 36'(cur.sd.by);
      npx = c[0] ? 36'(cur.nwx) : -36'(cur.nwx);
      npy = c[0] ? 36'(cur.nwy) : -36'(cur.nwy);
      un  = c[0] ? nxe : -nxe;
      vn  = c[0] ? nye : -nye;
      unique case (ct)
        CT_NEG: begin
          tpx = -36'(cur.twx);
          tpy = -36'(cur.nwx);
          ut  = nye;
          vt  = -nxe;
        end
        CT_POS: begin
          tpx = 36'(cur.twx);
          tpy = 36'(cur.nwx);
          ut  = -nye;
          vt  = nxe;
        end
        default: begin
          tpx = 36'sd0;
          tpy = 36'sd0;
          ut  = 18'sd0;
          vt  = 18'sd0;
        end
      endcase
    end else begin
      bpx = 36'(cur.sd.ax);
      bpy = 36'(cur.sd.ay);
      npx = dc[1] ? rr : -rr;
      npy = (dc == 2'd1 || dc == 2'd2) ? rr : -rr;
      tpx = 36'sd0;
      tpy = 36'sd0;
      un  = dc[1] ? TEX_ONE : -TEX_ONE;
      vn  = (dc == 2'd1 || dc == 2'd2) ? TEX_ONE : -TEX_ONE;
      ut  = 18'sd0;
      vt  = 18'sd0;
    end
    px = sat32(bpx + npx + tpx);
    py = sat32(bpy + npy + tpy);
    pu = sat16(un + ut);
    pv = sat16(vn + vt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      k         <= 5'd0;
    end else begin
      if (out_adv) out_valid <= cur_valid;
      if (geo_take) begin
        cur_valid <= 1'b1;
        k         <= 5'd0;
      end else if (out_adv && cur_valid) begin
        k <= k + 5'd1;
        if (at_last) cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (geo_take) cur <= geo;
    if (out_adv && cur_valid) begin
      vert_x      <= px;
      vert_y      <= py;
      vert_rgba   <= cur.sd.rgba;
      tex_u       <= pu;
      tex_v       <= pv;
      vert_index  <= k;
      last_vertex <= at_last;
    end
  end

endmodule

### hw/rtl/thick_segment_tessellator.sv
// Path: input, then the 57-stage geometry pipe, then the vertex emitter's registers.
// Throughput: one vertex per cycle while out_stall is low; a segment gives 18 vertices, a
// dot 6, counted by the vertex emitter; the geometry pipe takes a new item every cycle it
// is not stalled. Reset (rst, synchronous, active high) clears all valid bits and the
// emitter; no clearing pass.
module thick_segment_tessellator import tst_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] from_x,
  input  logic signed [31:0] from_y,
  input  logic signed [31:0] to_x,
  input  logic signed [31:0] to_y,
  input  logic [30:0]        radius,
  input  logic [31:0]        rgba,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] vert_x,
  output logic signed [31:0] vert_y,
  output logic [31:0]        vert_rgba,
  output logic signed [15:0] tex_u,
  output logic signed [15:0] tex_v,
  output logic [4:0]         vert_index,
  output logic               last_vertex
);

  side_t in_side;
  geo_t  geo;
  logic  geo_valid, geo_take;

  always_comb begin
    in_side.mode = mode;
    in_side.ax   = from_x;
    in_side.ay   = from_y;
    in_side.bx   = to_x;
    in_side.by   = to_y;
    in_side.r    = radius;
    in_side.rgba = rgba;
  end

  tst_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_side   (in_side),
    .geo_valid (geo_valid),
    .geo_take  (geo_take),
    .geo       (geo)
  );

  tst_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .geo_valid   (geo_valid),
    .geo_take    (geo_take),
    .geo         (geo),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .vert_rgba   (vert_rgba),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .vert_index  (vert_index),
    .last_vertex (last_vertex)
  );

endmodule

### hw/rtl/tst_checker.sv
`include "assert_macros.svh"

module tst_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] vert_x,
  input logic [4:0]  vert_index,
  input logic        last_vertex
);

  `TST_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(vert_x) && $stable(vert_index))
  `TST_ASSERT(a_last_idx, clk, rst, out_valid && last_vertex |-> vert_index == 5'd5 || vert_index == 5'd17)
  `TST_ASSERT_MSG(a_restart, clk, rst, out_valid && !out_stall && last_vertex ##1 out_valid |-> vert_index == 5'd0, "next primitive does not start at vertex 0")
  `TST_ASSERT_MSG(a_step, clk, rst, out_valid && !out_stall && !last_vertex ##1 out_valid |-> vert_index == 5'($past(vert_index) + 5'd1), "vertex index skipped")

endmodule

bind thick_segment_tessellator tst_checker u_tst_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .vert_x      (vert_x),
  .vert_index  (vert_index),
  .last_vertex (last_vertex)
);
